>>> src/lrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg: shared types for the link reconnect backoff sequencer
// Link modes, configuration register indexes, register file and result types.
// ----------------------------------------------------------------------------
package lrb_pkg;

  localparam int BACKOFF_ENTRIES = 5;
  localparam int BACKOFF_IDX_W   = $clog2(BACKOFF_ENTRIES);
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int CRED_COUNT_W    = 5;
  localparam int TIME_W          = 32;
  localparam int CRED_OUT_W      = 4;

  // last backoff slot, where the step saturates
  localparam logic [BACKOFF_IDX_W-1:0] BACKOFF_LAST = BACKOFF_IDX_W'(BACKOFF_ENTRIES - 1);

  // request word kinds
  localparam logic FUNC_POLL    = 1'b0;
  localparam logic FUNC_CONNECT = 1'b1;

  // reset values of the configuration registers
  localparam logic [CRED_COUNT_W-1:0] CRED_COUNT_RST = 5'd1;
  localparam logic [TIME_W-1:0]       TIMEOUT_RST    = 32'd9000;
  localparam logic [TIME_W-1:0]       BACKOFF_0_RST  = 32'd1000;
  localparam logic [TIME_W-1:0]       BACKOFF_1_RST  = 32'd2000;
  localparam logic [TIME_W-1:0]       BACKOFF_2_RST  = 32'd5000;
  localparam logic [TIME_W-1:0]       BACKOFF_3_RST  = 32'd15000;
  localparam logic [TIME_W-1:0]       BACKOFF_4_RST  = 32'd30000;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CRED_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_0  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_1  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_2  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_3  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_4  = 3'd6;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_CONNECTING = 2'd1,
    MODE_CONNECTED  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CRED_COUNT_W-1:0]                credential_count;
    logic [TIME_W-1:0]                      attempt_timeout_ms;
    logic [BACKOFF_ENTRIES-1:0][TIME_W-1:0] delay_tab;
  } cfg_regs_t;

  typedef struct packed {
    logic                  begin_attempt;
    logic [CRED_OUT_W-1:0] cred_index;
    logic [1:0]            link_state;
    logic                  all_failed;
    logic [TIME_W-1:0]     retry_delay_ms;
    logic                  connect_ok;
  } result_t;

endpackage

>>> src/lrb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_if: handshake channels of the link reconnect backoff sequencer
// Request, response and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface lrb_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [lrb_pkg::TIME_W-1:0] now_ms;
  logic                      link_up;

  modport source (output valid, func, now_ms, link_up, input ready);
  modport sink   (input valid, func, now_ms, link_up, output ready);
endinterface

interface lrb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          begin_attempt;
  logic [lrb_pkg::CRED_OUT_W-1:0] cred_index;
  logic [1:0]                    link_state;
  logic                          all_failed;
  logic [lrb_pkg::TIME_W-1:0]     retry_delay_ms;
  logic                          connect_ok;

  modport source (output valid, begin_attempt, cred_index, link_state, all_failed,
                  retry_delay_ms, connect_ok, input ready);
  modport sink   (input valid, begin_attempt, cred_index, link_state, all_failed,
                  retry_delay_ms, connect_ok, output ready);
endinterface

interface lrb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lrb_pkg::CFG_INDEX_W-1:0] index;
  logic [lrb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/lrb_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_step: one-word next-state and result logic
// Decodes a poll or connect word against the current sequencer state.
// ----------------------------------------------------------------------------
module lrb_step #(
  parameter int MAX_CREDENTIALS = 16
) (
  input  lrb_pkg::cfg_regs_t                          cfg,
  input  lrb_pkg::mode_t                              mode,
  input  logic [$clog2(MAX_CREDENTIALS+1)-1:0]        cred,
  input  logic [lrb_pkg::BACKOFF_IDX_W-1:0]           step,
  input  logic [lrb_pkg::TIME_W-1:0]                  start_time,
  input  logic [lrb_pkg::TIME_W-1:0]                  next_time,
  input  logic                                        func,
  input  logic [lrb_pkg::TIME_W-1:0]                  now_ms,
  input  logic                                        link_up,
  output lrb_pkg::mode_t                              mode_next,
  output logic [$clog2(MAX_CREDENTIALS+1)-1:0]        cred_next,
  output logic [lrb_pkg::BACKOFF_IDX_W-1:0]           step_next,
  output logic [lrb_pkg::TIME_W-1:0]                  start_time_next,
  output logic [lrb_pkg::TIME_W-1:0]                  next_time_next,
  output lrb_pkg::result_t                            result
);

  localparam int CW = $clog2(MAX_CREDENTIALS + 1);
  localparam int KW = (CW > lrb_pkg::CRED_COUNT_W) ? CW : lrb_pkg::CRED_COUNT_W;

  logic [KW-1:0]                     cc_k;
  logic [KW-1:0]                     max_k;
  logic [KW-1:0]                     count_k;
  logic [CW-1:0]                     count;
  logic                              has_creds;
  logic                              is_cmd;
  logic                              cmd_up;
  logic                              cmd_go;
  logic                              poll_up;
  logic                              poll_act;
  logic [lrb_pkg::TIME_W-1:0]        elapsed;
  logic                              timed_out;
  logic [CW:0]                       cred_inc;
  logic                              pass_end;
  logic                              due;
  logic [lrb_pkg::BACKOFF_IDX_W-1:0] bo_idx;
  logic [lrb_pkg::TIME_W-1:0]        bo_delay;

  // clamp the register count to the storage size
  assign cc_k      = KW'(cfg.credential_count);
  assign max_k     = KW'(MAX_CREDENTIALS);
  assign count_k   = (cc_k > max_k) ? max_k : cc_k;
  assign count     = CW'(count_k);
  assign has_creds = (count != '0);

  assign is_cmd   = (func == lrb_pkg::FUNC_CONNECT);
  assign cmd_up   = is_cmd & has_creds & link_up;
  assign cmd_go   = is_cmd & has_creds & ~link_up;
  assign poll_up  = ~is_cmd & link_up;
  assign poll_act = ~is_cmd & ~link_up & has_creds;

  // wrapping elapsed time
  assign elapsed   = now_ms - start_time;
  assign timed_out = (elapsed >= cfg.attempt_timeout_ms);
  assign cred_inc  = {1'b0, cred} + (CW+1)'(1);
  assign pass_end  = (cred_inc >= {1'b0, count});
  assign due       = (now_ms >= next_time);

  assign bo_idx   = (step < lrb_pkg::BACKOFF_LAST) ? step : lrb_pkg::BACKOFF_LAST;
  assign bo_delay = cfg.delay_tab[bo_idx];

  // next mode
  always_comb begin
    mode_next = mode;
    if (cmd_up || poll_up) begin
      mode_next = lrb_pkg::MODE_CONNECTED;
    end else if (cmd_go) begin
      mode_next = lrb_pkg::MODE_CONNECTING;
    end else if (poll_act) begin
      case (mode)
        lrb_pkg::MODE_CONNECTED: begin
          mode_next = lrb_pkg::MODE_IDLE;
        end
        lrb_pkg::MODE_CONNECTING: begin
          if (timed_out && pass_end) begin
            mode_next = lrb_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode_next = due ? lrb_pkg::MODE_CONNECTING : lrb_pkg::MODE_IDLE;
        end
      endcase
    end
  end

  // data state and result flags
  always_comb begin
    cred_next       = cred;
    step_next       = step;
    start_time_next = start_time;
    next_time_next  = next_time;
    result          = '0;
    if (cmd_up) begin
      result.connect_ok = 1'b1;
    end else if (cmd_go) begin
      cred_next            = '0;
      step_next            = '0;
      start_time_next      = now_ms;
      result.begin_attempt = 1'b1;
    end else if (poll_up) begin
      if (mode != lrb_pkg::MODE_CONNECTED) begin
        step_next = '0;
      end
    end else if (poll_act) begin
      case (mode)
        lrb_pkg::MODE_CONNECTED: begin
          cred_next      = '0;
          next_time_next = now_ms;
        end
        lrb_pkg::MODE_CONNECTING: begin
          if (timed_out) begin
            if (pass_end) begin
              cred_next             = '0;
              next_time_next        = now_ms + bo_delay;
              result.all_failed     = 1'b1;
              result.retry_delay_ms = bo_delay;
              if (step < lrb_pkg::BACKOFF_LAST) begin
                step_next = step + lrb_pkg::BACKOFF_IDX_W'(1);
              end
            end else begin
              cred_next            = CW'(cred_inc);
              start_time_next      = now_ms;
              result.begin_attempt = 1'b1;
            end
          end
        end
        default: begin
          if (due) begin
            start_time_next      = now_ms;
            result.begin_attempt = 1'b1;
          end
        end
      endcase
    end
    result.cred_index = lrb_pkg::CRED_OUT_W'(cred_next);
    result.link_state = mode_next;
  end

endmodule

>>> src/link_reconnect_backoff_fsm_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm_top: link reconnect sequencer with capped backoff
// Steps through saved credentials with a per-attempt timeout, then waits a
// backoff delay from a five-slot table before the next pass.
// ----------------------------------------------------------------------------
// path: a request word is held in the input register, then in the response
//   register, where it is offered as a response until it is taken
// throughput: one word per cycle while the receiver takes responses; the
//   single-pass step logic and the state update both close in the cycle the input register drains
// reset: rst (synchronous) empties both registers, sets mode idle with all
//   counters and times at zero, and loads the register defaults
module link_reconnect_backoff_fsm_top #(
  parameter int MAX_CREDENTIALS = 16
) (
  input logic      clk,
  input logic      rst,
  lrb_req_if.sink  req,
  lrb_rsp_if.source rsp,
  lrb_cfg_if.sink  cfg
);

  localparam int CW = $clog2(MAX_CREDENTIALS + 1);

  // configuration registers
  lrb_pkg::cfg_regs_t cfg_regs;

  // sequencer state
  lrb_pkg::mode_t                    mode;
  lrb_pkg::mode_t                    mode_next;
  logic [CW-1:0]                     cred;
  logic [CW-1:0]                     cred_next;
  logic [lrb_pkg::BACKOFF_IDX_W-1:0] step;
  logic [lrb_pkg::BACKOFF_IDX_W-1:0] step_next;
  logic [lrb_pkg::TIME_W-1:0]        start_time;
  logic [lrb_pkg::TIME_W-1:0]        start_time_next;
  logic [lrb_pkg::TIME_W-1:0]        next_time;
  logic [lrb_pkg::TIME_W-1:0]        next_time_next;

  // input register
  logic                       in_valid;
  logic                       in_func;
  logic [lrb_pkg::TIME_W-1:0] in_now;
  logic                       in_up;

  // response register
  logic             out_valid;
  lrb_pkg::result_t out_word;
  lrb_pkg::result_t step_result;

  logic advance;
  logic take;

  // the input register drains whenever the response register is free or
  // being emptied; it refills in the same cycle so words stream back to back
  assign advance   = in_valid & (~out_valid | rsp.ready);
  assign req.ready = ~in_valid | advance;
  assign take      = req.valid & req.ready;

  // registers are always writable; the sender must write them only while no word
  // is in flight, and the block itself does not enforce this
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.credential_count   <= lrb_pkg::CRED_COUNT_RST;
      cfg_regs.attempt_timeout_ms <= lrb_pkg::TIMEOUT_RST;
      cfg_regs.delay_tab[0]       <= lrb_pkg::BACKOFF_0_RST;
      cfg_regs.delay_tab[1]       <= lrb_pkg::BACKOFF_1_RST;
      cfg_regs.delay_tab[2]       <= lrb_pkg::BACKOFF_2_RST;
      cfg_regs.delay_tab[3]       <= lrb_pkg::BACKOFF_3_RST;
      cfg_regs.delay_tab[4]       <= lrb_pkg::BACKOFF_4_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        lrb_pkg::REG_CRED_COUNT: begin
          cfg_regs.credential_count <= cfg.data[lrb_pkg::CRED_COUNT_W-1:0];
        end
        lrb_pkg::REG_TIMEOUT:   cfg_regs.attempt_timeout_ms <= cfg.data;
        lrb_pkg::REG_BACKOFF_0: cfg_regs.delay_tab[0] <= cfg.data;
        lrb_pkg::REG_BACKOFF_1: cfg_regs.delay_tab[1] <= cfg.data;
        lrb_pkg::REG_BACKOFF_2: cfg_regs.delay_tab[2] <= cfg.data;
        lrb_pkg::REG_BACKOFF_3: cfg_regs.delay_tab[3] <= cfg.data;
        lrb_pkg::REG_BACKOFF_4: cfg_regs.delay_tab[4] <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // input register: payload loads on acceptance, no reset needed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_func <= req.func;
      in_now  <= req.now_ms;
      in_up   <= req.link_up;
    end
  end

  // combinational step for the word held in the input register
  lrb_step #(
    .MAX_CREDENTIALS (MAX_CREDENTIALS)
  ) u_step (
    .cfg             (cfg_regs),
    .mode            (mode),
    .cred            (cred),
    .step            (step),
    .start_time      (start_time),
    .next_time       (next_time),
    .func            (in_func),
    .now_ms          (in_now),
    .link_up         (in_up),
    .mode_next       (mode_next),
    .cred_next       (cred_next),
    .step_next       (step_next),
    .start_time_next (start_time_next),
    .next_time_next  (next_time_next),
    .result          (step_result)
  );

  // sequencer state commits as the word moves into the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= lrb_pkg::MODE_IDLE;
      cred       <= '0;
      step       <= '0;
      start_time <= '0;
      next_time  <= '0;
    end else if (advance) begin
      mode       <= mode_next;
      cred       <= cred_next;
      step       <= step_next;
      start_time <= start_time_next;
      next_time  <= next_time_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= step_result;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.begin_attempt  = out_word.begin_attempt;
  assign rsp.cred_index     = out_word.cred_index;
  assign rsp.link_state     = out_word.link_state;
  assign rsp.all_failed     = out_word.all_failed;
  assign rsp.retry_delay_ms = out_word.retry_delay_ms;
  assign rsp.connect_ok     = out_word.connect_ok;

endmodule

>>> src/lrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_checker: port-level checks for the link reconnect sequencer
// Response consistency and hold rules, bound onto the top level.
// ----------------------------------------------------------------------------
module lrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        begin_attempt,
  input logic [1:0]  link_state,
  input logic        all_failed,
  input logic [31:0] retry_delay_ms,
  input logic        connect_ok
);

  // a stalled response word stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // a failed pass ends in idle with no attempt started
  a_fail_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && all_failed |->
      link_state == lrb_pkg::MODE_IDLE && !begin_attempt && !connect_ok)
    else $error("failed pass not left idle");

  // starting a join puts the link in the connecting mode
  a_begin_conn: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && begin_attempt |-> link_state == lrb_pkg::MODE_CONNECTING)
    else $error("attempt started outside connecting mode");

  // a successful connect command reports connected
  a_ok_conn: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && connect_ok |-> link_state == lrb_pkg::MODE_CONNECTED)
    else $error("connect ok without connected mode");

  // a delay is only reported with a failed pass
  a_delay_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && retry_delay_ms != 32'd0 |-> all_failed)
    else $error("retry delay without failed pass");

endmodule

bind link_reconnect_backoff_fsm_top lrb_checker u_lrb_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .begin_attempt  (rsp.begin_attempt),
  .link_state     (rsp.link_state),
  .all_failed     (rsp.all_failed),
  .retry_delay_ms (rsp.retry_delay_ms),
  .connect_ok     (rsp.connect_ok)
);

>>> tb/sv/lrb_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_tb_pkg: scoreboard for the link reconnect backoff sequencer
// Tracks the sequencer state and register copies. It works out the expected
// result word for each accepted request and checks every result word.
// ----------------------------------------------------------------------------
package lrb_tb_pkg;
  import lrb_pkg::*;

  class reconnect_scoreboard;
    int unsigned max_creds;

    // register copies
    logic [CRED_COUNT_W-1:0] cred_count_reg;
    logic [TIME_W-1:0]       timeout_reg;
    logic [TIME_W-1:0]       backoff_reg [BACKOFF_ENTRIES];

    // sequencer state
    mode_t                    mode;
    logic [4:0]               cred_sel;
    logic [BACKOFF_IDX_W-1:0] backoff_step;
    logic [TIME_W-1:0]        attempt_start;
    logic [TIME_W-1:0]        next_attempt;

    result_t     expected_results [$];
    int unsigned mismatches;

    function new(int unsigned max_creds_in);
      max_creds      = max_creds_in;
      cred_count_reg = CRED_COUNT_RST;
      timeout_reg    = TIMEOUT_RST;
      backoff_reg[0] = BACKOFF_0_RST;
      backoff_reg[1] = BACKOFF_1_RST;
      backoff_reg[2] = BACKOFF_2_RST;
      backoff_reg[3] = BACKOFF_3_RST;
      backoff_reg[4] = BACKOFF_4_RST;
      mode           = MODE_IDLE;
      cred_sel       = '0;
      backoff_step   = '0;
      attempt_start  = '0;
      next_attempt   = '0;
      mismatches     = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_CRED_COUNT: cred_count_reg = data[CRED_COUNT_W-1:0];
        REG_TIMEOUT:    timeout_reg    = data;
        REG_BACKOFF_0:  backoff_reg[0] = data;
        REG_BACKOFF_1:  backoff_reg[1] = data;
        REG_BACKOFF_2:  backoff_reg[2] = data;
        REG_BACKOFF_3:  backoff_reg[3] = data;
        REG_BACKOFF_4:  backoff_reg[4] = data;
        default: ;
      endcase
    endfunction

    function void note_request(logic func, logic [TIME_W-1:0] now, logic up);
      int unsigned              usable;
      logic [TIME_W-1:0]        elapsed;
      logic [BACKOFF_IDX_W-1:0] slot;
      result_t                  want;
      usable = (cred_count_reg > max_creds) ? max_creds : cred_count_reg;
      want   = '0;
      if (func == FUNC_CONNECT) begin
        if (usable != 0) begin
          if (up) begin
            mode            = MODE_CONNECTED;
            want.connect_ok = 1'b1;
          end else begin
            cred_sel           = '0;
            backoff_step       = '0;
            attempt_start      = now;
            mode               = MODE_CONNECTING;
            want.begin_attempt = 1'b1;
          end
        end
      end else if (up) begin
        if (mode != MODE_CONNECTED) begin
          mode         = MODE_CONNECTED;
          backoff_step = '0;
        end
      end else if (usable != 0) begin
        case (mode)
          MODE_CONNECTED: begin
            mode         = MODE_IDLE;
            cred_sel     = '0;
            next_attempt = now;
          end
          MODE_CONNECTING: begin
            elapsed = now - attempt_start;
            if (elapsed >= timeout_reg) begin
              cred_sel = cred_sel + 5'd1;
              if (cred_sel >= usable) begin
                slot = (backoff_step < BACKOFF_LAST) ? backoff_step : BACKOFF_LAST;
                want.retry_delay_ms = backoff_reg[slot];
                want.all_failed     = 1'b1;
                if (backoff_step < BACKOFF_LAST) backoff_step = backoff_step + 1'b1;
                next_attempt = now + want.retry_delay_ms;
                cred_sel     = '0;
                mode         = MODE_IDLE;
              end else begin
                attempt_start      = now;
                want.begin_attempt = 1'b1;
              end
            end
          end
          default: begin
            mode = MODE_IDLE;
            if (now >= next_attempt) begin
              attempt_start      = now;
              mode               = MODE_CONNECTING;
              want.begin_attempt = 1'b1;
            end
          end
        endcase
      end
      want.cred_index = cred_sel[CRED_OUT_W-1:0];
      want.link_state = mode;
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result word with nothing expected, expected none, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("begin_attempt", 32'(want.begin_attempt), 32'(got.begin_attempt));
      compare_field("cred_index", 32'(want.cred_index), 32'(got.cred_index));
      compare_field("link_state", 32'(want.link_state), 32'(got.link_state));
      compare_field("all_failed", 32'(want.all_failed), 32'(got.all_failed));
      compare_field("retry_delay_ms", want.retry_delay_ms, got.retry_delay_ms);
      compare_field("connect_ok", 32'(want.connect_ok), 32'(got.connect_ok));
    endfunction
  endclass

endpackage

>>> tb/sv/tb_link_reconnect_backoff_fsm_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_link_reconnect_backoff_fsm_top: testbench for the reconnect sequencer
// Directed words walk through timeouts, backoff, link drops, connect commands
// and count changes. Random phases of poll traffic then run over several
// register settings, most with idle gaps on both sides. Each result word is checked
// against the scoreboard.
// ----------------------------------------------------------------------------
module tb_link_reconnect_backoff_fsm_top;
  import lrb_pkg::*;
  import lrb_tb_pkg::*;

  localparam int          MAX_CREDS   = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst;

  lrb_req_if req_ch ();
  lrb_rsp_if rsp_ch ();
  lrb_cfg_if cfg_ch ();

  link_reconnect_backoff_fsm_top #(
    .MAX_CREDENTIALS(MAX_CREDS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  reconnect_scoreboard link_sb;

  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       cycle_count = 0;
  logic [TIME_W-1:0] clock_ms;     // millisecond time carried from word to word
  logic              link_level;   // link state the random traffic follows

  // 10 ns clock
  always #5 clk = ~clk;

  // receiver stalls at random, never during the last phases
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL link_reconnect_backoff_fsm_top");
      $finish;
    end
  end

  // sample every handshake at the clock edge; register writes first, so a
  // request in the same edge sees the new setting
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) link_sb.write_register(cfg_ch.index, cfg_ch.data);
      if (req_ch.valid && req_ch.ready)
        link_sb.note_request(req_ch.func, req_ch.now_ms, req_ch.link_up);
      if (rsp_ch.valid && rsp_ch.ready)
        link_sb.check_result('{begin_attempt:  rsp_ch.begin_attempt,
                               cred_index:     rsp_ch.cred_index,
                               link_state:     rsp_ch.link_state,
                               all_failed:     rsp_ch.all_failed,
                               retry_delay_ms: rsp_ch.retry_delay_ms,
                               connect_ok:     rsp_ch.connect_ok});
    end
  end

  // one request word; valid stays high into the next word unless an idle
  // cycle is drawn
  task automatic send_word(input logic func, input logic [TIME_W-1:0] now, input logic up);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= func;
    req_ch.now_ms  <= now;
    req_ch.link_up <= up;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // register write; the caller lowers valid after the last one
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result word
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (link_sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] count,
                               input logic [TIME_W-1:0] timeout,
                               input logic [TIME_W-1:0] b0, input logic [TIME_W-1:0] b1,
                               input logic [TIME_W-1:0] b2, input logic [TIME_W-1:0] b3,
                               input logic [TIME_W-1:0] b4);
    write_reg(REG_CRED_COUNT, count);
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_BACKOFF_0, b0);
    write_reg(REG_BACKOFF_1, b1);
    write_reg(REG_BACKOFF_2, b2);
    write_reg(REG_BACKOFF_3, b3);
    write_reg(REG_BACKOFF_4, b4);
    cfg_ch.valid <= 1'b0;
  endtask

  // random phase: mostly polls with time moving forward, a link that comes
  // and goes, the odd connect command, time jumps and link noise
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic [CFG_DATA_W-1:0] count,
                           input logic [TIME_W-1:0] timeout,
                           input logic [TIME_W-1:0] b0, input logic [TIME_W-1:0] b1,
                           input logic [TIME_W-1:0] b2, input logic [TIME_W-1:0] b3,
                           input logic [TIME_W-1:0] b4,
                           input logic [TIME_W-1:0] step_max, input int unsigned words);
    int unsigned pick;
    logic        func;
    logic        up;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    load_settings(count, timeout, b0, b1, b2, b3, b4);
    repeat (words) begin
      pick = $urandom_range(99);
      if (pick < 4) clock_ms = $urandom;
      else if (pick >= 12) clock_ms = clock_ms + $urandom_range(step_max);
      // link rises rarely and drops more often, so passes get to run out
      if (link_level) begin
        if ($urandom_range(99) < 15) link_level = 1'b0;
      end else begin
        if ($urandom_range(99) < 4) link_level = 1'b1;
      end
      func = ($urandom_range(99) < 6) ? FUNC_CONNECT : FUNC_POLL;
      up   = ($urandom_range(99) < 5) ? 1'($urandom) : link_level;
      send_word(func, clock_ms, up);
    end
  endtask

  initial begin
    rst            = 1'b1;
    send_idle_pct  = 23;
    recv_idle_pct  = 77;
    clock_ms       = '0;
    link_level     = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.func    = FUNC_POLL;
    req_ch.now_ms  = '0;
    req_ch.link_up = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_CRED_COUNT;
    cfg_ch.data    = '0;
    link_sb        = new(MAX_CREDS);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one credential, 9000 ms timeout
    send_word(FUNC_POLL, 32'd0, 1'b0);            // first attempt at once
    send_word(FUNC_POLL, 32'd8999, 1'b0);         // one short of the timeout
    send_word(FUNC_POLL, 32'd9000, 1'b0);         // timeout, pass fails, first backoff
    send_word(FUNC_POLL, 32'd9999, 1'b0);         // still backing off
    send_word(FUNC_POLL, 32'd10000, 1'b0);        // backoff over, new pass
    send_word(FUNC_CONNECT, 32'd10500, 1'b1);     // connect with link already up
    send_word(FUNC_POLL, 32'd20000, 1'b0);        // link dropped
    send_word(FUNC_POLL, 32'd20000, 1'b0);        // immediate new pass
    send_word(FUNC_POLL, 32'd20001, 1'b1);        // link up clears the backoff
    send_word(FUNC_CONNECT, 32'hFFFF_FFFF, 1'b0); // connect restarts at the top of time
    send_word(FUNC_POLL, 32'h0000_2327, 1'b0);    // elapsed wraps to exactly the timeout

    // four credentials, huge first backoff
    wait_idle();
    write_reg(REG_CRED_COUNT, 32'd4);
    write_reg(REG_BACKOFF_0, 32'hFFFF_FF00);
    cfg_ch.valid <= 1'b0;
    send_word(FUNC_CONNECT, 32'd100, 1'b0);
    send_word(FUNC_POLL, 32'd9100, 1'b0);
    send_word(FUNC_POLL, 32'd18100, 1'b0);

    // count lowered mid-pass: next timeout ends the pass
    wait_idle();
    write_reg(REG_CRED_COUNT, 32'd1);
    cfg_ch.valid <= 1'b0;
    send_word(FUNC_POLL, 32'd27100, 1'b0);        // backoff wraps the next attempt time
    send_word(FUNC_POLL, 32'd27101, 1'b0);        // so the next attempt fires at once

    // no credentials
    wait_idle();
    write_reg(REG_CRED_COUNT, 32'd0);
    cfg_ch.valid <= 1'b0;
    send_word(FUNC_CONNECT, 32'd30000, 1'b1);
    send_word(FUNC_CONNECT, 32'd30001, 1'b0);
    send_word(FUNC_POLL, 32'd30002, 1'b1);
    send_word(FUNC_POLL, 32'd30003, 1'b0);

    // count above the parameter, capped
    wait_idle();
    write_reg(REG_CRED_COUNT, 32'd31);
    cfg_ch.valid <= 1'b0;
    send_word(FUNC_POLL, 32'd50000, 1'b0);
    send_word(FUNC_POLL, 32'd50000, 1'b0);
    send_word(FUNC_POLL, 32'hFFFF_FFFF, 1'b0);
    clock_ms = 32'd60000;

    // sender light, receiver heavy
    run_phase(23, 77, 32'd3, 32'd40, 32'd10, 32'd20, 32'd30, 32'd40, 32'd50, 32'd60, 150);
    run_phase(23, 77, 32'd16, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 150);
    // sender heavy, receiver light
    run_phase(77, 23, 32'd31, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h8000_0000,
              32'h7FFF_FFFF, 32'hFFFF_0000, 32'd20, 150);
    run_phase(77, 23, 32'd0, 32'd100, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd50, 80);
    // no idling at all
    run_phase(0, 0, 32'd2, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              32'hFFFF_FFFF, 130);
    run_phase(0, 0, 32'd5, TIMEOUT_RST, BACKOFF_0_RST, BACKOFF_1_RST, BACKOFF_2_RST,
              BACKOFF_3_RST, BACKOFF_4_RST, 32'd4000, 220);

    wait_idle();
    repeat (4) @(posedge clk);
    if (link_sb.mismatches == 0 && link_sb.expected_results.size() == 0) begin
      $display("PASS link_reconnect_backoff_fsm_top");
    end else begin
      $display("FAIL link_reconnect_backoff_fsm_top");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lrb_pkg.sv
src/lrb_if.sv
src/lrb_step.sv
src/link_reconnect_backoff_fsm_top.sv
src/lrb_checker.sv
tb/sv/lrb_tb_pkg.sv
tb/sv/tb_link_reconnect_backoff_fsm_top.sv
